>>> rtl/cc20_pkg.sv
// Shared types, constants and helper functions for the ChaCha20 stream cipher unit.
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned STREAM_W = 72;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA0 = 32'd1634760805;
    localparam logic [31:0] SIGMA1 = 32'd857760878;
    localparam logic [31:0] SIGMA2 = 32'd2036477234;
    localparam logic [31:0] SIGMA3 = 32'd1797285236;

    localparam logic [3:0] REG_KEY0       = 4'd0;
    localparam logic [3:0] REG_KEY1       = 4'd1;
    localparam logic [3:0] REG_KEY2       = 4'd2;
    localparam logic [3:0] REG_KEY3       = 4'd3;
    localparam logic [3:0] REG_NONCE_LOW  = 4'd4;
    localparam logic [3:0] REG_NONCE_HIGH = 4'd5;
    localparam logic [3:0] REG_START_CTR  = 4'd6;
    localparam logic [3:0] REG_ROUNDS     = 4'd7;

    localparam logic [3:0] RESET_ROUNDS = 4'd10;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
        logic [31:0] start_counter;
        logic [3:0]  double_rounds;
    } cc20_cfg_t;

    localparam cc20_cfg_t CFG_RESET = {64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0,
                                       RESET_ROUNDS};

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ROUND,
        BS_FINAL
    } blk_state_t;

    typedef enum logic {
        ST_IDLE,
        ST_GEN
    } top_state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } qr_lane_t;

    // Half a quarter round: rotations 16/12 for the first half, 8/7 for the second.
    function automatic qr_lane_t qr_half(input qr_lane_t v, input logic second);
        qr_lane_t r;
        logic [31:0] t;
        r = v;
        r.a = r.a + r.b;
        t   = r.d ^ r.a;
        r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
        r.c = r.c + r.d;
        t   = r.b ^ r.c;
        r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
        return r;
    endfunction

    // XOR with keystream (or pass keystream) and zero bytes at or above count.
    function automatic logic [63:0] ks_apply(input logic [63:0] data, input logic [63:0] ks,
                                             input logic [3:0] count, input logic ks_only);
        logic [63:0] r;
        r = ks_only ? ks : (data ^ ks);
        for (int i = 0; i < 8; i++) begin
            if (4'(i) >= count) begin
                r[8*i +: 8] = 8'h00;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/chacha20_stream_cipher_unit.sv
// Top level of the ChaCha20 (96-bit nonce) stream cipher unit.
// Each input transaction carries one 64-bit message word and yields one output
// transaction: the word XORed with the next eight keystream bytes, or the raw
// keystream when tuser is set; bytes at or above the byte count read as zero.
// Words that draw on a fresh 64-byte block (the first word of a message and
// every eighth word after it) wait for the block generator, which runs four
// quarter-round lanes at half a quarter round per cycle; no word is accepted
// while a block is generated. The other seven words of a block are accepted
// and registered straight from the stored block. The output register frees the
// input side as soon as the held result is taken. The user must write
// configuration only while no message word is in flight; the block itself does
// not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_stream_cipher_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [3:0]                    cfg_index,
    input  wire logic [63:0]                   cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cc20_pkg::STREAM_W-1:0] s_tdata,  // data_word[63:0], byte_count[67:64]
    input  wire logic                          s_tlast,
    input  wire logic                          s_tuser,  // keystream_only
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [cc20_pkg::STREAM_W-1:0]      m_tdata,  // out_word[63:0], out_byte_count[67:64]
    output logic                               m_tlast
);
    import cc20_pkg::*;

    cc20_cfg_t           cfg_reg, cfg_next;
    top_state_t          state_reg, state_next;
    logic [31:0]         ctr_reg, ctr_next, ctr_eff;
    logic [2:0]          pos_reg, pos_next, pos_eff;
    logic                in_msg_reg, in_msg_next;
    logic [DATA_W-1:0]   hold_data_reg, hold_data_next;
    logic [CNT_W-1:0]    hold_cnt_reg, hold_cnt_next;
    logic                hold_last_reg, hold_last_next;
    logic                hold_kso_reg, hold_kso_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STREAM_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;
    logic                slot_free, accept, need_blk, blk_start, blk_done, out_load;
    logic [2:0]          rd_idx;
    logic [63:0]         ks_row;
    logic [DATA_W-1:0]   src_data;
    logic [CNT_W-1:0]    src_cnt;
    logic                src_last, src_kso;

    cc20_block u_block (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (blk_start),
        .ctr_in  (ctr_eff),
        .cfg     (cfg_reg),
        .rd_idx  (rd_idx),
        .rd_data (ks_row),
        .done    (blk_done)
    );

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY0:       cfg_next.key0          = cfg_data;
                REG_KEY1:       cfg_next.key1          = cfg_data;
                REG_KEY2:       cfg_next.key2          = cfg_data;
                REG_KEY3:       cfg_next.key3          = cfg_data;
                REG_NONCE_LOW:  cfg_next.nonce_low     = cfg_data;
                REG_NONCE_HIGH: cfg_next.nonce_high    = cfg_data[31:0];
                REG_START_CTR:  cfg_next.start_counter = cfg_data[31:0];
                REG_ROUNDS:     cfg_next.double_rounds = cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign slot_free = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign ctr_eff   = in_msg_reg ? ctr_reg : cfg_reg.start_counter;
    assign pos_eff   = in_msg_reg ? pos_reg : 3'd0;
    assign need_blk  = (pos_eff == 3'd0);
    assign blk_start = accept && need_blk;
    assign rd_idx    = (state_reg == ST_GEN) ? 3'd0 : pos_eff;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && need_blk) begin
                    state_next = ST_GEN;
                end
            end
            ST_GEN: begin
                if (blk_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        out_load       = 1'b0;
        ctr_next       = ctr_reg;
        pos_next       = pos_reg;
        in_msg_next    = in_msg_reg;
        hold_data_next = hold_data_reg;
        hold_cnt_next  = hold_cnt_reg;
        hold_last_next = hold_last_reg;
        hold_kso_next  = hold_kso_reg;
        src_data       = s_tdata[DATA_W-1:0];
        src_cnt        = s_tdata[DATA_W +: CNT_W];
        src_last       = s_tlast;
        src_kso        = s_tuser;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = slot_free;
                if (accept) begin
                    in_msg_next = !s_tlast;
                    pos_next    = pos_eff + 3'd1;
                    if (need_blk) begin
                        ctr_next       = ctr_eff + 32'd1;
                        hold_data_next = s_tdata[DATA_W-1:0];
                        hold_cnt_next  = s_tdata[DATA_W +: CNT_W];
                        hold_last_next = s_tlast;
                        hold_kso_next  = s_tuser;
                    end else begin
                        out_load = 1'b1;
                    end
                end
            end
            ST_GEN: begin
                src_data = hold_data_reg;
                src_cnt  = hold_cnt_reg;
                src_last = hold_last_reg;
                src_kso  = hold_kso_reg;
                out_load = blk_done;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {STREAM_W'({src_cnt, ks_apply(src_data, ks_row, src_cnt, src_kso)})};
            m_tlast_next  = src_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= CFG_RESET;
            state_reg    <= ST_IDLE;
            ctr_reg      <= 32'd0;
            pos_reg      <= 3'd0;
            in_msg_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            state_reg    <= state_next;
            ctr_reg      <= ctr_next;
            pos_reg      <= pos_next;
            in_msg_reg   <= in_msg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_data_reg <= hold_data_next;
        hold_cnt_reg  <= hold_cnt_next;
        hold_last_reg <= hold_last_next;
        hold_kso_reg  <= hold_kso_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

>>> rtl/cc20_block.sv
// ChaCha block generator: four quarter-round lanes, half a quarter round per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cc20_block (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [31:0]         ctr_in,
    input  wire cc20_pkg::cc20_cfg_t cfg,
    input  wire logic [2:0]          rd_idx,
    output logic [63:0]              rd_data,
    output logic                     done
);
    import cc20_pkg::*;

    blk_state_t        state_reg, state_next;
    logic [WORD_W-1:0] x_reg [16];
    logic [WORD_W-1:0] x_next [16];
    logic [WORD_W-1:0] init_w [16];
    logic [31:0]       ctr_reg, ctr_next, ctr_sel;
    logic [1:0]        step_reg, step_next;
    logic [3:0]        round_reg, round_next;
    logic              done_reg, done_next;
    qr_lane_t          lane_in [4];
    qr_lane_t          lane_out [4];
    logic [3:0]        idx_b [4];
    logic [3:0]        idx_c [4];
    logic [3:0]        idx_d [4];

    assign ctr_sel = (state_reg == BS_IDLE) ? ctr_in : ctr_reg;

    always_comb begin
        init_w[0]  = SIGMA0;
        init_w[1]  = SIGMA1;
        init_w[2]  = SIGMA2;
        init_w[3]  = SIGMA3;
        init_w[4]  = cfg.key0[31:0];
        init_w[5]  = cfg.key0[63:32];
        init_w[6]  = cfg.key1[31:0];
        init_w[7]  = cfg.key1[63:32];
        init_w[8]  = cfg.key2[31:0];
        init_w[9]  = cfg.key2[63:32];
        init_w[10] = cfg.key3[31:0];
        init_w[11] = cfg.key3[63:32];
        init_w[12] = ctr_sel;
        init_w[13] = cfg.nonce_low[31:0];
        init_w[14] = cfg.nonce_low[63:32];
        init_w[15] = cfg.nonce_high;
    end

    // Lane operand routing: columns on step[1] == 0, diagonals otherwise.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            idx_b[i] = {2'b01, 2'(i) + (step_reg[1] ? 2'd1 : 2'd0)};
            idx_c[i] = {2'b10, 2'(i) + (step_reg[1] ? 2'd2 : 2'd0)};
            idx_d[i] = {2'b11, 2'(i) + (step_reg[1] ? 2'd3 : 2'd0)};
            lane_in[i].a = x_reg[4'(i)];
            lane_in[i].b = x_reg[idx_b[i]];
            lane_in[i].c = x_reg[idx_c[i]];
            lane_in[i].d = x_reg[idx_d[i]];
            lane_out[i]  = qr_half(lane_in[i], step_reg[0]);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE: begin
                if (start) begin
                    state_next = (cfg.double_rounds == 4'd0) ? BS_FINAL : BS_ROUND;
                end
            end
            BS_ROUND: begin
                if (step_reg == 2'd3 && round_reg == cfg.double_rounds - 4'd1) begin
                    state_next = BS_FINAL;
                end
            end
            BS_FINAL: begin
                state_next = BS_IDLE;
            end
            default: begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        x_next     = x_reg;
        ctr_next   = ctr_reg;
        step_next  = step_reg;
        round_next = round_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            BS_IDLE: begin
                if (start) begin
                    x_next     = init_w;
                    ctr_next   = ctr_in;
                    step_next  = 2'd0;
                    round_next = 4'd0;
                end
            end
            BS_ROUND: begin
                for (int i = 0; i < 4; i++) begin
                    x_next[4'(i)]    = lane_out[i].a;
                    x_next[idx_b[i]] = lane_out[i].b;
                    x_next[idx_c[i]] = lane_out[i].c;
                    x_next[idx_d[i]] = lane_out[i].d;
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    round_next = round_reg + 4'd1;
                end
            end
            BS_FINAL: begin
                for (int i = 0; i < 16; i++) begin
                    x_next[i] = x_reg[i] + init_w[i];
                end
                done_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BS_IDLE;
            step_reg  <= 2'd0;
            round_reg <= 4'd0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        ctr_reg <= ctr_next;
    end

    assign rd_data = {x_reg[{rd_idx, 1'b1}], x_reg[{rd_idx, 1'b0}]};
    assign done    = done_reg;

endmodule

`default_nettype wire

>>> rtl/cc20_checker.sv
// Port-level checks for the ChaCha20 stream cipher unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cc20_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tlast
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output transaction changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output slot is blocked");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[67:64] == 4'd0) |-> (m_tdata[63:0] == 64'd0))
    else $error("zero byte count with nonzero output bytes");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[67:64] == 4'd1) |-> (m_tdata[63:8] == 56'd0))
    else $error("bytes beyond byte count not cleared");

endmodule

bind chacha20_stream_cipher_unit cc20_checker u_cc20_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
